@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL of the linked list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define AST_CHECK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define AST_NEVER(lbl, clk, rstn, cond, msg) \
	`AST_CHECK(lbl, clk, rstn, !(cond), msg)

`endif

@@ hw/rtl/alfl_pkg.sv @@
// ----------------------------------------------------------------------------
// alfl_pkg
// Types, constants and codes of the array linked list with free list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alfl_pkg;

	localparam int NODE_COUNT = 64;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int LINK_W     = $clog2(NODE_COUNT + 1);
	localparam int STEP_W     = IDX_W;

	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODE_COUNT);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NODE_COUNT - 1);

	localparam int OP_W     = 2;
	localparam int KEY_W    = 64;
	localparam int PHONE_W  = 64;
	localparam int COMP_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int GUEST_W  = 15;
	localparam int PAY_W    = KEY_W + PHONE_W + COMP_W;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [KEY_W-1:0]   name_key;
		logic [PHONE_W-1:0] phone;
		logic [COMP_W-1:0]  companions;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    found_key;
		logic [PHONE_W-1:0]  found_phone;
		logic [COMP_W-1:0]   found_companions;
		logic                last;
		logic [COUNT_W-1:0]  entry_count;
		logic [GUEST_W-1:0]  guest_total;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_INS_WR,
		S_WALK_REM,
		S_WALK_LK,
		S_REM_PREV,
		S_REM_CUR,
		S_FIN_OK,
		S_FIN_FULL,
		S_FIN_MISS,
		S_FIN_PEND
	} state_t;

	typedef enum logic [2:0] {
		EM_OK,
		EM_FULL,
		EM_MISS,
		EM_PEND_MORE,
		EM_PEND_LAST
	} emit_t;

	typedef struct packed {
		logic  load_item;
		logic  ins_start;
		logic  ins_commit;
		logic  walk_start;
		logic  walk_adv;
		logic  rem_prev;
		logic  rem_cur;
		logic  pend_load;
		logic  emit;
		emit_t emit_kind;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            head_null;
		logic            free_null;
		logic            key_match;
		logic            walk_end;
		logic            out_free;
		logic            pend_valid;
	} stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/alfl_ram.sv @@
// ----------------------------------------------------------------------------
// alfl_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// Read data holds while no read is issued.
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/alfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// alfl_ctrl
// Controller of the linked list: sequences insert, remove and lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfl_ctrl
	import alfl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   hit_go;

	// A lookup hit may proceed once any pending hit can be pushed out.
	assign hit_go = stat.key_match && (!stat.pend_valid || stat.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.op)
					OP_INSERT: state_d = stat.free_null ? S_FIN_FULL : S_INS_RD;
					OP_REMOVE: state_d = stat.head_null ? S_FIN_MISS : S_WALK_REM;
					OP_LOOKUP: state_d = stat.head_null ? S_FIN_MISS : S_WALK_LK;
					default:   state_d = S_FIN_OK;
				endcase
			end
			S_INS_RD: state_d = S_INS_WR;
			S_INS_WR: state_d = S_FIN_OK;
			S_WALK_REM: begin
				if (stat.key_match) begin
					state_d = S_REM_PREV;
				end else if (stat.walk_end) begin
					state_d = S_FIN_MISS;
				end
			end
			S_WALK_LK: begin
				if (hit_go && stat.walk_end) begin
					state_d = S_FIN_PEND;
				end else if (!stat.key_match && stat.walk_end) begin
					state_d = stat.pend_valid ? S_FIN_PEND : S_FIN_MISS;
				end
			end
			S_REM_PREV: state_d = S_REM_CUR;
			S_REM_CUR:  state_d = S_FIN_OK;
			S_FIN_OK, S_FIN_FULL, S_FIN_MISS, S_FIN_PEND: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_DISPATCH: begin
				cmd.ins_start  = (stat.op == OP_INSERT) && !stat.free_null;
				cmd.walk_start = ((stat.op == OP_REMOVE) || (stat.op == OP_LOOKUP)) &&
				                 !stat.head_null;
			end
			S_INS_WR: cmd.ins_commit = 1'b1;
			S_WALK_REM: begin
				cmd.walk_adv = !stat.key_match && !stat.walk_end;
			end
			S_WALK_LK: begin
				if (stat.key_match) begin
					if (hit_go) begin
						cmd.pend_load = 1'b1;
						cmd.walk_adv  = !stat.walk_end;
						if (stat.pend_valid) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = EM_PEND_MORE;
						end
					end
				end else begin
					cmd.walk_adv = !stat.walk_end;
				end
			end
			S_REM_PREV: cmd.rem_prev = 1'b1;
			S_REM_CUR:  cmd.rem_cur = 1'b1;
			S_FIN_OK: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = EM_OK;
			end
			S_FIN_FULL: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = EM_FULL;
			end
			S_FIN_MISS: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = EM_MISS;
			end
			S_FIN_PEND: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = EM_PEND_LAST;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/alfl_dp.sv @@
// ----------------------------------------------------------------------------
// alfl_dp
// Datapath of the linked list: node memories, heads, counters and result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfl_dp
	import alfl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_word_t  in_data,
	input  wire cmd_t      cmd,
	output stat_t          stat,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	in_word_t            item_q;
	logic [LINK_W-1:0]   list_head_q;
	logic [LINK_W-1:0]   free_head_q;
	logic [LINK_W-1:0]   cur_q;
	logic [LINK_W-1:0]   prev_q;
	logic [STEP_W-1:0]   steps_q;
	logic [COUNT_W-1:0]  count_q;
	logic [GUEST_W-1:0]  guest_q;
	logic                link_valid_q [NODE_COUNT];
	logic                pend_valid_q;
	logic [KEY_W-1:0]    pend_key_q;
	logic [PHONE_W-1:0]  pend_phone_q;
	logic [COMP_W-1:0]   pend_comp_q;
	logic                out_valid_q;
	out_word_t           out_q;
	out_word_t           out_d;

	logic                link_re;
	logic [IDX_W-1:0]    link_raddr;
	logic [LINK_W-1:0]   link_rdata;
	logic                link_we;
	logic [IDX_W-1:0]    link_waddr;
	logic [LINK_W-1:0]   link_wdata;
	logic [PAY_W-1:0]    pay_wdata;
	logic [PAY_W-1:0]    pay_rdata;

	logic [IDX_W-1:0]    cur_idx;
	logic [LINK_W-1:0]   link_raw;
	logic [LINK_W-1:0]   link_eff;
	logic [KEY_W-1:0]    pay_key;
	logic [PHONE_W-1:0]  pay_phone;
	logic [COMP_W-1:0]   pay_comp;
	logic                out_free;

	assign cur_idx   = cur_q[IDX_W-1:0];
	assign pay_key   = pay_rdata[PAY_W-1 -: KEY_W];
	assign pay_phone = pay_rdata[COMP_W +: PHONE_W];
	assign pay_comp  = pay_rdata[COMP_W-1:0];

	// A link never written since reset reads as its reset value, node plus one.
	assign link_raw = link_valid_q[cur_idx] ? link_rdata : (cur_q + LINK_W'(1));
	assign link_eff = (link_raw >= LINK_NULL) ? LINK_NULL : link_raw;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		link_re    = cmd.walk_start || cmd.walk_adv || cmd.ins_start;
		link_raddr = link_eff[IDX_W-1:0];
		if (cmd.walk_start) begin
			link_raddr = list_head_q[IDX_W-1:0];
		end else if (cmd.ins_start) begin
			link_raddr = free_head_q[IDX_W-1:0];
		end

		link_we    = cmd.ins_commit || cmd.rem_cur || (cmd.rem_prev && (prev_q != LINK_NULL));
		link_waddr = cmd.rem_prev ? prev_q[IDX_W-1:0] : cur_idx;
		link_wdata = free_head_q;
		if (cmd.ins_commit) begin
			link_wdata = list_head_q;
		end else if (cmd.rem_prev) begin
			link_wdata = link_eff;
		end

		pay_wdata = {item_q.name_key, item_q.phone, item_q.companions};
	end

	alfl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (NODE_COUNT)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	alfl_ram #(
		.WIDTH (PAY_W),
		.DEPTH (NODE_COUNT)
	) u_pay_ram (
		.clk   (clk),
		.we    (cmd.ins_start),
		.waddr (free_head_q[IDX_W-1:0]),
		.wdata (pay_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (pay_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q  <= LINK_NULL;
			free_head_q  <= '0;
			cur_q        <= LINK_NULL;
			prev_q       <= LINK_NULL;
			steps_q      <= '0;
			count_q      <= '0;
			guest_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NODE_COUNT; i++) begin
				link_valid_q[i] <= 1'b0;
			end
		end else begin
			if (link_we) begin
				link_valid_q[link_waddr] <= 1'b1;
			end
			if (cmd.ins_start) begin
				cur_q <= free_head_q;
			end
			if (cmd.ins_commit) begin
				free_head_q <= link_eff;
				list_head_q <= cur_q;
				count_q     <= count_q + COUNT_W'(1);
				guest_q     <= guest_q + GUEST_W'(item_q.companions) + GUEST_W'(1);
			end
			if (cmd.walk_start) begin
				cur_q        <= list_head_q;
				prev_q       <= LINK_NULL;
				steps_q      <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.walk_adv) begin
				prev_q  <= cur_q;
				cur_q   <= link_eff;
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.rem_prev && (prev_q == LINK_NULL)) begin
				list_head_q <= link_eff;
			end
			if (cmd.rem_cur) begin
				free_head_q <= cur_q;
				count_q     <= count_q - COUNT_W'(1);
				guest_q     <= guest_q - GUEST_W'(pay_comp) - GUEST_W'(1);
			end
			if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.emit && (cmd.emit_kind == EM_PEND_LAST)) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
		if (cmd.pend_load) begin
			pend_key_q   <= pay_key;
			pend_phone_q <= pay_phone;
			pend_comp_q  <= pay_comp;
		end
		if (cmd.emit) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		out_d                  = '0;
		out_d.status           = ST_OK;
		out_d.last             = 1'b1;
		out_d.entry_count      = count_q;
		out_d.guest_total      = guest_q;
		case (cmd.emit_kind)
			EM_OK:   out_d.status = ST_OK;
			EM_FULL: out_d.status = ST_FULL;
			EM_MISS: out_d.status = ST_MISSING;
			EM_PEND_MORE, EM_PEND_LAST: begin
				out_d.found_key        = pend_key_q;
				out_d.found_phone      = pend_phone_q;
				out_d.found_companions = pend_comp_q;
				out_d.last             = (cmd.emit_kind == EM_PEND_LAST);
			end
			default: out_d.status = ST_OK;
		endcase
	end

	always_comb begin
		stat.op         = item_q.opcode;
		stat.head_null  = (list_head_q == LINK_NULL);
		stat.free_null  = (free_head_q == LINK_NULL);
		stat.key_match  = (pay_key == item_q.name_key);
		stat.walk_end   = (link_eff == LINK_NULL) || (steps_q == STEP_LAST);
		stat.out_free   = out_free;
		stat.pend_valid = pend_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/array_linked_list_with_free_list.sv @@
// ----------------------------------------------------------------------------
// array_linked_list_with_free_list
// Linked list over a fixed node pool with a free list for node recycling.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one word per operation:
// insert at head, remove first match, or lookup of all matches by key. The
// output channel (out_valid, out_ready, out_data) returns result words; a
// lookup returns one word per matching entry in list order, with last set on
// the final one, or one miss word if none matches; every other operation
// returns exactly one word. One operation is in flight at a time. An insert
// reads the free head, then links the node in. Remove and lookup follow the
// list one node per cycle through the link memory; a lookup holds on a hit
// while an earlier buffered hit cannot be passed on. A remove that finds its
// node rewrites the previous link or the head, then frees the node. At most
// NODE_COUNT nodes are visited. The next word is accepted in the cycle after
// the previous result is loaded, even while that result waits to be taken.
// If the receiver stalls, the result waits in the output register; a lookup
// holds its walk until the buffered hit can be passed on.
// Reset empties the list and links every node into the free list at once,
// with no clearing pass; the block can accept a word on the first cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module array_linked_list_with_free_list
	import alfl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_word_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_data
);

	cmd_t  cmd;
	stat_t stat;

	alfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	alfl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`AST_CHECK(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready,
		"word accepted while an operation is in flight")
	`AST_NEVER(a_no_overwrite, clk, arst_n, cmd.emit && !stat.out_free,
		"result loaded over a waiting result")
	`AST_CHECK(a_more_is_hit, clk, arst_n,
		(out_valid && !out_data.last) |-> (out_data.status == ST_OK),
		"non-final result that is not a hit")
	`AST_CHECK(a_walk_and_insert, clk, arst_n,
		!(cmd.walk_adv && (cmd.ins_commit || cmd.rem_cur)),
		"link walk overlaps a list update")

endmodule

`default_nettype wire
